// ===== rtl/gbp_pkg.sv =====
// Shared constants and controller/datapath interface types for the gshare
// branch predictor. No dependencies.
`default_nettype none

package gbp_pkg;

  localparam int unsigned INDEX_BITS_DEF = 12;

  localparam int unsigned PC_W        = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned S_TDATA_W   = 40;  // pc, resolved, predicted, pad
  localparam int unsigned M_TDATA_W   = 8;   // predict_taken, pad

  localparam logic [MODE_W-1:0] MODE_GSHARE = 2'd2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [1:0] CTR_ZERO       = 2'd0;
  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CTR_MAX        = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // write one reset entry, advance sweep pointer
    logic accept;  // capture item, start table read
    logic commit;  // write back counter / load prediction
  } gbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;    // sweep pointer at last entry
    logic is_predict;  // held item is a predict request
  } gbp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/gbp_datapath.sv =====
// Datapath: counter table memory, global history, mode register, item and
// result registers. Depends on gbp_pkg; driven by gbp_ctrl commands.
`default_nettype none

module gbp_datapath
  import gbp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gbp_cmd_t             cmd_i,
  output gbp_sts_t                  sts_o,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic                 s_tuser_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [MODE_W-1:0]    cfg_data_i,
  output logic                      pred_bit_o
);

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  logic [1:0]            mem [DEPTH];
  logic [1:0]            rd_q;
  logic [INDEX_BITS-1:0] idx_in;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  op_q, res_q, pred_q;
  logic [INDEX_BITS-1:0] hist_q;
  logic [INDEX_BITS-1:0] clr_cnt_q;
  logic [MODE_W-1:0]     mode_q;
  logic                  pred_bit_q;
  logic                  gshare;
  logic                  upd_en;
  logic                  in_res, in_pred;
  logic [1:0]            ctr_d;

  assign in_res  = s_tdata_i[PC_W];
  assign in_pred = s_tdata_i[PC_W+1];
  assign idx_in  = s_tdata_i[INDEX_BITS-1:0] ^ hist_q;
  assign gshare  = (mode_q == MODE_GSHARE);
  assign upd_en  = cmd_i.commit && (op_q == OP_UPDATE) && gshare;

  // agreeing outcome saturates, disagreeing one steps toward resolved
  always_comb begin
    ctr_d = rd_q;
    if (res_q == pred_q) begin
      ctr_d = res_q ? CTR_MAX : CTR_ZERO;
    end else if (pred_q) begin
      if (rd_q != CTR_ZERO) ctr_d = rd_q - 2'd1;
    end else begin
      if (rd_q != CTR_MAX) ctr_d = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_cnt_q] <= CTR_WEAK_TAKEN;
    end else if (upd_en) begin
      mem[idx_q] <= ctr_d;
    end
    if (cmd_i.accept) begin
      rd_q   <= mem[idx_in];
      idx_q  <= idx_in;
      op_q   <= s_tuser_i;
      res_q  <= in_res;
      pred_q <= in_pred;
    end
    if (cmd_i.commit && (op_q == OP_PREDICT)) begin
      pred_bit_q <= gshare ? rd_q[1] : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      clr_cnt_q <= '0;
      mode_q    <= MODE_GSHARE;
    end else begin
      if (upd_en) hist_q <= {hist_q[INDEX_BITS-2:0], res_q};
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) mode_q <= cfg_data_i;
    end
  end

  assign sts_o.clr_last   = &clr_cnt_q;
  assign sts_o.is_predict = (op_q == OP_PREDICT);
  assign pred_bit_o       = pred_bit_q;

endmodule

`default_nettype wire

// ===== rtl/gbp_ctrl.sv =====
// Controller: reset sweep, accept/resolve sequencing and output valid.
// Depends on gbp_pkg; drives gbp_datapath.
`default_nettype none

module gbp_ctrl
  import gbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  wire logic     m_tready_i,
  input  wire gbp_sts_t sts_i,
  output gbp_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_busy;

  assign out_busy     = out_valid_q && !m_tready_i;
  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.accept = (state_q == ST_IDLE) && s_tvalid_i;
  // a prediction waits while the previous one is still unclaimed
  assign cmd_o.commit = (state_q == ST_RESOLVE) && !(sts_i.is_predict && out_busy);
  assign s_tready_o   = (state_q == ST_IDLE);
  assign m_tvalid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR:   if (sts_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE:    if (s_tvalid_i) state_q <= ST_RESOLVE;
        ST_RESOLVE: if (cmd_o.commit) state_q <= ST_IDLE;
        default:    state_q <= ST_IDLE;
      endcase
      if (cmd_o.commit && sts_i.is_predict) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gshare_branch_predictor_core.sv =====
// gshare branch predictor with 2-bit saturating counters, top level.
// Depends on gbp_pkg, gbp_ctrl, gbp_datapath.
//
// After reset the block sweeps the counter table to weakly taken, one entry
// per cycle; no item is taken meanwhile, mode writes are. Items are taken
// one at a time: the table read is registered on accept, the counter
// write-back or prediction happens in the resolve state, which a waiting
// prediction can stall. A prediction sits in an output register, so the
// next item can be taken while it waits; a second prediction stalls until
// it is claimed. Mode writes must be made only while the block is idle.
`default_nettype none

module gshare_branch_predictor_core
  import gbp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [31:0] branch_pc, [32] resolved_taken, [33] predicted_taken, rest zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] op
  input  wire logic                 s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [0] predict_taken, rest zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [MODE_W-1:0]    cfg_data_i
);

  gbp_cmd_t cmd;
  gbp_sts_t sts;
  logic     pred_bit;

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {{(M_TDATA_W-1){1'b0}}, pred_bit};

  gbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .pred_bit_o (pred_bit)
  );

endmodule

`default_nettype wire

// ===== tb/gshare_branch_predictor_core_tb.sv =====
// Self-checking testbench for gshare_branch_predictor_core: random stream traffic
// checked against an in-bench gshare predictor. Depends on gbp_pkg and the core RTL.
`timescale 1ns / 100ps

module gshare_branch_predictor_core_tb;
  import gbp_pkg::*;

  localparam int unsigned IDX_W = INDEX_BITS_DEF;
  localparam logic [MODE_W-1:0] MODE_PERFECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALWAYS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic            op;
    logic [PC_W-1:0] pc;
    logic            resolved;
    logic            predicted;
  } branch_item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [MODE_W-1:0]    cfg_data_i;

  gshare_branch_predictor_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor state mirrored in the bench
  logic [1:0]        ctr_tbl [2**IDX_W];
  logic [IDX_W-1:0]  ghist;
  logic [MODE_W-1:0] cur_mode;

  branch_item_t branch_queue[$];
  logic         predicted_dirs[$];
  logic [PC_W-1:0] pc_pool[8];

  bit in_fire;
  bit no_idle;
  int err_cnt;
  int send_gap;
  int stall_left;
  int rx_hold_left;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_item(logic op, logic [PC_W-1:0] pc, logic res, logic pred);
    branch_item_t it;
    it.op        = op;
    it.pc        = pc;
    it.resolved  = res;
    it.predicted = pred;
    branch_queue.push_back(it);
  endfunction

  // gshare lookup / training for one accepted transfer
  function automatic void track_branch(logic op, logic [PC_W-1:0] pc, logic res, logic pred);
    logic [IDX_W-1:0] idx;
    logic [1:0]       ctr;
    idx = pc[IDX_W-1:0] ^ ghist;
    ctr = ctr_tbl[idx];
    if (op == OP_PREDICT) begin
      predicted_dirs.push_back((cur_mode != MODE_GSHARE) || (ctr >= CTR_WEAK_TAKEN));
    end else if (cur_mode == MODE_GSHARE) begin
      if (res == pred) begin
        ctr = res ? CTR_MAX : CTR_ZERO;
      end else if (pred) begin
        if (ctr != CTR_ZERO) ctr = ctr - 2'd1;
      end else begin
        if (ctr != CTR_MAX) ctr = ctr + 2'd1;
      end
      ctr_tbl[idx] = ctr;
      ghist = {ghist[IDX_W-2:0], res};
    end
  endfunction

  // sampling side: check results, then train on accepted items
  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (predicted_dirs.size() == 0) begin
        $display("%0t: unexpected prediction, expected none actual %0b",
                 $time, m_axis_tdata_o[0]);
        err_cnt++;
      end else begin
        logic exp_dir;
        exp_dir = predicted_dirs.pop_front();
        if (m_axis_tdata_o[0] !== exp_dir) begin
          $display("%0t: predict_taken mismatch, expected %0b actual %0b",
                   $time, exp_dir, m_axis_tdata_o[0]);
          err_cnt++;
        end
      end
    end
    if (in_fire)
      track_branch(s_axis_tuser_i, s_axis_tdata_i[PC_W-1:0],
                   s_axis_tdata_i[PC_W], s_axis_tdata_i[PC_W+1]);
  end

  // item driver
  always @(negedge clk_i) begin
    branch_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (branch_queue.size() > 0) begin
        it = branch_queue.pop_front();
        s_axis_tuser_i  <= it.op;
        s_axis_tdata_i  <= {6'b0, it.predicted, it.resolved, it.pc};
        s_axis_tvalid_i <= 1'b1;
        send_gap = draw_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = draw_gap();
    end
  end

  task automatic set_mode(input logic [MODE_W-1:0] m);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every item has gone and every prediction has come back
  task automatic drain();
    do @(posedge clk_i);
    while (branch_queue.size() > 0 || s_axis_tvalid_i || predicted_dirs.size() > 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic gen_random(input int n);
    int made;
    int kind;
    int len;
    logic [PC_W-1:0] pc;
    logic dir;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // loop-like branch: mostly one direction, so history and counter saturate
        pc  = (kind == 0) ? pc_pool[3'($urandom_range(0, 7))] : $urandom;
        dir = 1'($urandom_range(0, 1));
        len = $urandom_range(3, 10);
        repeat (len) begin
          push_item(OP_PREDICT, pc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          push_item(OP_UPDATE, pc, ($urandom_range(0, 7) == 0) ? !dir : dir,
                    1'($urandom_range(0, 1)));
          made += 2;
        end
      end else if (kind < 8) begin
        pc = pc_pool[3'($urandom_range(0, 7))];
        push_item(OP_PREDICT, pc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_item(OP_UPDATE, pc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made += 2;
      end else begin
        push_item(1'($urandom_range(0, 1)), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_PREDICT;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = MODE_GSHARE;
    in_fire         = 1'b0;
    no_idle         = 1'b0;
    err_cnt         = 0;
    send_gap        = 0;
    stall_left      = 0;
    rx_hold_left    = 0;
    ghist           = '0;
    cur_mode        = MODE_GSHARE;
    foreach (ctr_tbl[i]) ctr_tbl[i] = CTR_WEAK_TAKEN;
    foreach (pc_pool[i]) pc_pool[i] = $urandom;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // table sweep runs now; the mode write is taken meanwhile
    set_mode(MODE_GSHARE);

    // directed: address extremes, each counter rule, saturation both ways
    push_item(OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0);
    push_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(OP_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
    push_item(OP_UPDATE,  32'h0000_0001, 1'b0, 1'b0);
    push_item(OP_PREDICT, 32'h0000_0002, 1'b0, 1'b0);
    push_item(OP_UPDATE,  32'h0000_0002, 1'b1, 1'b0);
    push_item(OP_UPDATE,  32'h0000_0005, 1'b1, 1'b0);
    push_item(OP_UPDATE,  32'h0000_000B, 1'b1, 1'b0);
    push_item(OP_UPDATE,  32'h0000_0017, 1'b1, 1'b0);
    push_item(OP_UPDATE,  32'h0000_002F, 1'b0, 1'b1);
    push_item(OP_UPDATE,  32'h0000_005E, 1'b0, 1'b1);
    push_item(OP_UPDATE,  32'h0000_00BC, 1'b0, 1'b1);
    push_item(OP_UPDATE,  32'h0000_0178, 1'b0, 1'b1);
    push_item(OP_PREDICT, 32'h0000_02F0, 1'b0, 1'b0);
    push_item(OP_PREDICT, 32'hFFFF_F2F0, 1'b0, 1'b0);
    push_item(OP_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0);
    drain();

    // other modes predict taken and leave the table alone
    set_mode(MODE_PERFECT);
    push_item(OP_PREDICT, 32'h0000_02F0, 1'b0, 1'b0);
    push_item(OP_UPDATE,  32'h0000_02F0, 1'b0, 1'b0);
    drain();
    set_mode(MODE_ALWAYS);
    push_item(OP_UPDATE,  32'h0000_02F0, 1'b1, 1'b0);
    push_item(OP_PREDICT, 32'h0000_02F0, 1'b0, 1'b0);
    drain();
    set_mode(MODE_UNUSED);
    push_item(OP_PREDICT, 32'h0000_02F0, 1'b0, 1'b0);
    push_item(OP_UPDATE,  32'h0000_02F0, 1'b0, 1'b1);
    drain();
    set_mode(MODE_GSHARE);
    push_item(OP_PREDICT, 32'hFFFF_F2F0, 1'b0, 1'b0);
    drain();

    gen_random(120);
    drain();

    // back-to-back items against a receiver held off: block fills and stalls
    no_idle      = 1'b1;
    rx_hold_left = 300;
    gen_random(80);
    drain();
    no_idle = 1'b0;

    set_mode(MODE_PERFECT);
    gen_random(40);
    drain();
    set_mode(MODE_ALWAYS);
    gen_random(30);
    drain();
    set_mode(MODE_UNUSED);
    gen_random(20);
    drain();
    set_mode(MODE_GSHARE);
    gen_random(340);
    drain();

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gbp_pkg.sv
rtl/gbp_datapath.sv
rtl/gbp_ctrl.sv
rtl/gshare_branch_predictor_core.sv
tb/gshare_branch_predictor_core_tb.sv
